@@ rtl/plst_pkg.sv @@
`default_nettype none

package plst_pkg;

    // Default number of list cells.
    localparam int CAPACITY_DEF = 16;

    // Field widths of the stream payloads.
    localparam int ACTION_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 5;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_INS_FRONT = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_INS_BACK  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_INS_POS   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_FRONT = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DEL_BACK  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_READ      = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Where an insert places the new entry.
    typedef enum logic [1:0] {
        INS_FRONT = 2'd0,
        INS_BACK  = 2'd1,
        INS_POS   = 2'd2
    } ins_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load;
        logic                ins;
        ins_sel_t            ins_sel;
        logic                del_front;
        logic                del_back;
        logic                rd;
        logic [STATUS_W-1:0] status;
    } plst_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_zero;
        logic count_full;
        logic ins_pos_ok;
        logic rd_pos_ok;
    } plst_stat_t;

endpackage

`default_nettype wire

@@ rtl/plst_ctrl.sv @@
`default_nettype none

module plst_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [plst_pkg::ACTION_W-1:0] action,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    input  wire plst_pkg::plst_stat_t          stat,
    output plst_pkg::plst_cmd_t                cmd
);
    import plst_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // A new transaction is taken when no result waits or the waiting one leaves now.
    assign in_ready  = (state_reg == S_IDLE) || out_ready;
    assign out_valid = (state_reg == S_HOLD);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        case (state_reg)
            S_IDLE:
            begin
                state_next = accept ? S_HOLD : S_IDLE;
            end
            S_HOLD:
            begin
                if (accept)
                    state_next = S_HOLD;
                else if (out_ready)
                    state_next = S_IDLE;
                else
                    state_next = S_HOLD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Decode the action and check it against the list status.
    always_comb
    begin
        cmd           = '0;
        cmd.ins_sel   = INS_FRONT;
        cmd.status    = ST_OK;
        cmd.load      = accept;
        case (action)
            ACT_INS_FRONT:
            begin
                if (stat.count_full)
                    cmd.status = ST_FULL;
                else
                begin
                    cmd.ins     = accept;
                    cmd.ins_sel = INS_FRONT;
                end
            end
            ACT_INS_BACK:
            begin
                if (stat.count_full)
                    cmd.status = ST_FULL;
                else
                begin
                    cmd.ins     = accept;
                    cmd.ins_sel = INS_BACK;
                end
            end
            ACT_INS_POS:
            begin
                if (!stat.ins_pos_ok)
                    cmd.status = ST_BADPOS;
                else if (stat.count_full)
                    cmd.status = ST_FULL;
                else
                begin
                    cmd.ins     = accept;
                    cmd.ins_sel = INS_POS;
                end
            end
            ACT_DEL_FRONT:
            begin
                if (stat.count_zero)
                    cmd.status = ST_EMPTY;
                else
                    cmd.del_front = accept;
            end
            ACT_DEL_BACK:
            begin
                if (stat.count_zero)
                    cmd.status = ST_EMPTY;
                else
                    cmd.del_back = accept;
            end
            ACT_READ:
            begin
                if (stat.count_zero)
                    cmd.status = ST_EMPTY;
                else if (!stat.rd_pos_ok)
                    cmd.status = ST_BADPOS;
                else
                    cmd.rd = accept;
            end
            default:
            begin
                cmd.status = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/plst_datapath.sv @@
`default_nettype none

module plst_datapath #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [plst_pkg::VALUE_W-1:0]  value,
    input  wire logic        [plst_pkg::POS_W-1:0]    position,
    input  wire plst_pkg::plst_cmd_t                  cmd,
    output plst_pkg::plst_stat_t                      stat,
    output logic             [plst_pkg::STATUS_W-1:0] status,
    output logic signed      [plst_pkg::VALUE_W-1:0]  read_value,
    output logic             [plst_pkg::TOTAL_W-1:0]  entry_total
);
    import plst_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // Compare width wide enough for the count, the position and one more.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    logic signed [VALUE_W-1:0]  cells_reg [CAPACITY];
    logic signed [VALUE_W-1:0]  cells_next [CAPACITY];
    logic        [CNT_W-1:0]    count_reg;
    logic        [CNT_W-1:0]    count_next;
    logic        [STATUS_W-1:0] status_reg;
    logic signed [VALUE_W-1:0]  rdval_reg;
    logic signed [VALUE_W-1:0]  rdval_next;

    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] pos_m1;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] ins_idx;

    // Position checks against the current count.
    assign pos_ext = CMP_W'(position);
    assign cnt_ext = CMP_W'(count_reg);
    assign pos_m1  = pos_ext - CMP_W'(1);
    assign pos_idx = pos_m1[IDX_W-1:0];

    assign stat.count_zero = (count_reg == '0);
    assign stat.count_full = (count_reg >= CNT_W'(CAPACITY));
    assign stat.ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
    assign stat.rd_pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

    // Cell index that the new entry takes.
    always_comb
    begin
        case (cmd.ins_sel)
            INS_FRONT: ins_idx = '0;
            INS_BACK:  ins_idx = count_reg[IDX_W-1:0];
            INS_POS:   ins_idx = pos_idx;
            default:   ins_idx = '0;
        endcase
    end

    // Each cell takes its own value, its lower neighbor's, its upper neighbor's or the new one.
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            cells_next[k] = cells_reg[k];
            if (cmd.ins)
            begin
                if (IDX_W'(k) == ins_idx)
                    cells_next[k] = value;
                else if ((k > 0) && (IDX_W'(k) > ins_idx))
                    cells_next[k] = cells_reg[(k > 0) ? k - 1 : 0];
            end
            else if (cmd.del_front && (k < CAPACITY - 1))
            begin
                cells_next[k] = cells_reg[(k < CAPACITY - 1) ? k + 1 : k];
            end
        end
    end

    // Entry count follows inserts and deletes.
    always_comb
    begin
        count_next = count_reg;
        if (cmd.ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.del_front || cmd.del_back)
            count_next = count_reg - CNT_W'(1);
    end

    assign rdval_next = cmd.rd ? cells_reg[pos_idx] : '0;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
            cells_reg[k] <= cells_next[k];
        if (cmd.load)
        begin
            status_reg <= cmd.status;
            rdval_reg  <= rdval_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    // The count only changes with a new result, so it belongs to the held one.
    assign status      = status_reg;
    assign read_value  = rdval_reg;
    assign entry_total = TOTAL_W'(count_reg);

endmodule

`default_nettype wire

@@ rtl/positional_list_store.sv @@
// Positional list store: an ordered list of up to CAPACITY signed 32-bit values.
// Action transactions arrive on the s_ channel (s_tvalid, s_tready, s_tdata) and
// each one gives exactly one result transaction on the m_ channel.
// s_tdata carries action, value and position; m_tdata returns status, the value
// read and the entry count after the action.
// Actions: insert at front, back or a 1-based position, delete front or back,
// and read the entry at a 1-based position.
// The result is in the output register the cycle after the action is accepted.
// Throughput, with no stall, is one action per cycle; every cell of the
// list shifts in parallel and the count register updates in that same cycle.
// The output register decouples the two sides: a new action is accepted in the
// same cycle the held result is taken. While the receiver stalls, the result
// holds and s_tready stays low, so the next action waits at the sender.
// Reset clears the entry count and the output valid; cell contents are not
// cleared, since only entries below the count are ever read.
`default_nettype none

module positional_list_store #(
    parameter int CAPACITY = plst_pkg::CAPACITY_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // s_tdata: action[2:0], value[34:3], position[39:35]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,
    // m_tdata: status[1:0], read_value[33:2], entry_total[38:34], zero[39]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata
);
    import plst_pkg::*;

    plst_cmd_t                 cmd;
    plst_stat_t                stat;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] read_value;
    logic [TOTAL_W-1:0]        entry_total;

    // Controller: handshake and action decode.
    plst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .action    (s_tdata[2:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Datapath: list cells, count and result registers.
    plst_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (s_tdata[34:3]),
        .position    (s_tdata[39:35]),
        .cmd         (cmd),
        .stat        (stat),
        .status      (status),
        .read_value  (read_value),
        .entry_total (entry_total)
    );

    assign m_tdata = {1'b0, entry_total, read_value, status};

    // An accepted transaction always leaves a result behind it.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted transaction produced no result");

    // Inserts never go into a full list.
    a_no_ins_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ins |-> !stat.count_full)
        else $error("insert issued into a full list");

    // Reads only address entries that are held.
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (stat.rd_pos_ok && !stat.count_zero))
        else $error("read issued outside the held entries");

    // At most one list operation per cycle, reads included.
    a_one_change: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.ins, cmd.del_front, cmd.del_back, cmd.rd}))
        else $error("more than one list operation in a cycle");

endmodule

`default_nettype wire
